>>> rtl/core/sfq_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sfq_pkg
// Shared sizes, codes and types of the searchable queue.
// -----------------------------------------------------------------------------
package sfq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int DATA_W      = 32;
   localparam int POS_W       = 5;

   typedef enum logic [1:0] {
      REQ_ENQUEUE = 2'd0,
      REQ_DEQUEUE = 2'd1,
      REQ_SEARCH  = 2'd2,
      REQ_NOP     = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      STS_OK    = 2'd0,
      STS_EMPTY = 2'd1,
      STS_FULL  = 2'd2,
      STS_RSVD  = 2'd3
   } status_type;

   // broadcast to every cell
   typedef struct packed {
      logic shift;    // move toward head (dequeue)
      logic compare;  // capture match flag (search)
   } cell_ctrl_type;

endpackage

>>> rtl/core/sfq_cell.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sfq_cell
// One queue slot: holds a value, shifts toward the head, compares to a key.
// -----------------------------------------------------------------------------
module sfq_cell (
   input  logic                               clock,
   input  sfq_pkg::cell_ctrl_type             ctrl_i,
   input  logic                               load_i,
   input  logic                               occupied_i,
   input  logic signed [sfq_pkg::DATA_W-1:0]  load_value_i,
   input  logic signed [sfq_pkg::DATA_W-1:0]  next_value_i,
   input  logic signed [sfq_pkg::DATA_W-1:0]  key_i,
   output logic signed [sfq_pkg::DATA_W-1:0]  value_o,
   output logic                               hit_o
);

   logic signed [sfq_pkg::DATA_W-1:0] value_ff;
   logic                              hit_ff;

   always_ff @(posedge clock) begin
      if (load_i) begin
         value_ff <= load_value_i;
      end else if (ctrl_i.shift) begin
         value_ff <= next_value_i;
      end
      if (ctrl_i.compare) begin
         hit_ff <= occupied_i && (value_ff == key_i);
      end
   end

   assign value_o = value_ff;
   assign hit_o   = hit_ff;

endmodule

>>> rtl/core/sfq_first_hit.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sfq_first_hit
// Finds the match flag nearest the head and turns it into a 1-based position.
// -----------------------------------------------------------------------------
module sfq_first_hit (
   input  logic [sfq_pkg::QUEUE_DEPTH-1:0] hit_i,
   output logic                            found_o,
   output logic [sfq_pkg::POS_W-1:0]       position_o
);

   logic [sfq_pkg::IDX_W-1:0] first_idx;
   logic [31:0]               pos_wide;

   // lowest index wins: scan down so the head-most hit is written last
   always_comb begin
      first_idx = '0;
      for (int i = sfq_pkg::QUEUE_DEPTH - 1; i >= 0; i--) begin
         if (hit_i[i]) begin
            first_idx = sfq_pkg::IDX_W'(i);
         end
      end
   end

   assign pos_wide   = 32'(first_idx) + 32'd1;
   assign found_o    = |hit_i;
   assign position_o = found_o ? pos_wide[sfq_pkg::POS_W-1:0] : '0;

endmodule

>>> rtl/core/searchable_fifo_queue.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// searchable_fifo_queue
// Bounded FIFO of signed 32-bit values with search for the oldest match.
// -----------------------------------------------------------------------------
// Flow: the accepting edge captures the request and the per-cell match flags;
//   the resolve state turns the flags into the first-match position and
//   registers the result. busy holds off a new request until then.
// Reset: synchronous, active high; queue empty, no result pending.
// The result strobe lasts one cycle; the receiver cannot stall it.
// -----------------------------------------------------------------------------
module searchable_fifo_queue (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_type,
   input  logic signed [sfq_pkg::DATA_W-1:0]  req_value,
   output logic                               rsp_valid,
   output logic [1:0]                         rsp_status,
   output logic signed [sfq_pkg::DATA_W-1:0]  rsp_data_out,
   output logic                               rsp_found,
   output logic [sfq_pkg::POS_W-1:0]          rsp_position
);

   localparam int DEPTH = sfq_pkg::QUEUE_DEPTH;

   typedef enum logic {
      ST_IDLE,
      ST_RESOLVE
   } state_type;

   // ---------------------------------------------------------------------
   // Control and occupancy
   // ---------------------------------------------------------------------
   state_type                     state_ff;
   logic                          busy_ff;
   logic                          rsp_valid_ff;
   logic [sfq_pkg::COUNT_W-1:0]   count_ff;
   logic [sfq_pkg::COUNT_W-1:0]   count_in;

   // request captured at the transfer, finished in the resolve cycle
   sfq_pkg::req_kind_type         op_ff;
   sfq_pkg::status_type           status_ff;
   logic signed [sfq_pkg::DATA_W-1:0] deq_data_ff;

   // result registers
   logic [1:0]                        rsp_status_ff;
   logic signed [sfq_pkg::DATA_W-1:0] rsp_data_ff;
   logic                              rsp_found_ff;
   logic [sfq_pkg::POS_W-1:0]         rsp_position_ff;

   logic                   accept;
   sfq_pkg::req_kind_type  kind;
   logic                   is_full;
   logic                   is_empty;
   logic                   do_enq;
   logic                   do_deq;
   sfq_pkg::status_type    status_in;
   sfq_pkg::cell_ctrl_type cell_ctrl;

   assign accept   = start && !busy_ff;
   assign kind     = sfq_pkg::req_kind_type'(req_type);
   assign is_full  = (count_ff == sfq_pkg::COUNT_W'(DEPTH));
   assign is_empty = (count_ff == '0);
   assign do_enq   = accept && (kind == sfq_pkg::REQ_ENQUEUE) && !is_full;
   assign do_deq   = accept && (kind == sfq_pkg::REQ_DEQUEUE) && !is_empty;

   assign cell_ctrl.shift   = do_deq;
   assign cell_ctrl.compare = accept && (kind == sfq_pkg::REQ_SEARCH);

   always_comb begin
      count_in = count_ff;
      if (do_enq) begin
         count_in = count_ff + 1'b1;
      end else if (do_deq) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_comb begin
      status_in = sfq_pkg::STS_OK;
      if (kind == sfq_pkg::REQ_ENQUEUE && is_full) begin
         status_in = sfq_pkg::STS_FULL;
      end else if (kind == sfq_pkg::REQ_DEQUEUE && is_empty) begin
         status_in = sfq_pkg::STS_EMPTY;
      end
   end

   // ---------------------------------------------------------------------
   // Cell chain: cell 0 is the head; an enqueue loads the cell at index count.
   // A dequeue shifts every cell one place toward the head.
   // ---------------------------------------------------------------------
   logic signed [sfq_pkg::DATA_W-1:0] cell_value [DEPTH];
   logic [DEPTH-1:0]                  cell_hit;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic                              occupied;
      logic                              load;
      logic signed [sfq_pkg::DATA_W-1:0] next_value;

      assign occupied = (sfq_pkg::COUNT_W'(g) < count_ff);
      assign load     = do_enq && (count_ff == sfq_pkg::COUNT_W'(g));

      if (g == DEPTH - 1) begin : g_last
         assign next_value = '0;
      end else begin : g_mid
         assign next_value = cell_value[g+1];
      end

      sfq_cell u_cell (
         .clock        (clock),
         .ctrl_i       (cell_ctrl),
         .load_i       (load),
         .occupied_i   (occupied),
         .load_value_i (req_value),
         .next_value_i (next_value),
         .key_i        (req_value),
         .value_o      (cell_value[g]),
         .hit_o        (cell_hit[g])
      );
   end

   // first match over the registered hit flags
   logic                    first_found;
   logic [sfq_pkg::POS_W-1:0] first_pos;

   sfq_first_hit u_first_hit (
      .hit_i      (cell_hit),
      .found_o    (first_found),
      .position_o (first_pos)
   );

   // ---------------------------------------------------------------------
   // Sequencer: state, occupancy and strobe
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_RESOLVE;
                  busy_ff  <= 1'b1;
               end
            end
            ST_RESOLVE: begin
               state_ff     <= ST_IDLE;
               busy_ff      <= 1'b0;
               rsp_valid_ff <= 1'b1;
            end
            default: begin
               state_ff <= ST_IDLE;
               busy_ff  <= 1'b0;
            end
         endcase
      end
   end

   // payload: captured at the transfer, result built in the resolve cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff       <= kind;
         status_ff   <= status_in;
         deq_data_ff <= do_deq ? cell_value[0] : '0;
      end
      if (state_ff == ST_RESOLVE) begin
         rsp_status_ff <= status_ff;
         rsp_data_ff   <= deq_data_ff;
         if (op_ff == sfq_pkg::REQ_SEARCH) begin
            rsp_found_ff    <= first_found;
            rsp_position_ff <= first_pos;
         end else begin
            rsp_found_ff    <= 1'b0;
            rsp_position_ff <= '0;
         end
      end
   end

   assign busy         = busy_ff;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_data_out = rsp_data_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_position_ff;

endmodule

>>> bench/searchable_fifo_queue_test.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// searchable_fifo_queue_test
// Self-checking bench for the searchable FIFO: enqueue, dequeue, search, no-op.
// A short directed table covers empty, full, extreme values, near misses and
// duplicate matches. Randomized fill, drain and balanced phases follow, with
// random idle gaps. Every accepted transfer goes through a shadow queue that
// predicts the result. Each result strobe is compared field by field with the
// oldest pending prediction.
// -----------------------------------------------------------------------------
module searchable_fifo_queue_test;
   import sfq_pkg::*;

   localparam int CLOCK_HIGH_NS = 6;
   localparam int CLOCK_LOW_NS  = 6;
   localparam int RESET_CYCLES  = 5;
   localparam int RANDOM_ITEMS  = 1850;  // not counting no-ops
   localparam int DRAIN_EVERY   = 400;   // random transfers between forced drains
   localparam int SETTLE_CYCLES = 8;     // well past the result latency
   localparam int CYCLE_LIMIT   = 400000;
   localparam int PRINT_LIMIT   = 50;
   localparam int RECENT_DEPTH  = 20;

   // one result of the queue
   typedef struct packed {
      status_type             status;
      logic [DATA_W-1:0]      data;
      logic                   found;
      logic [POS_W-1:0]       position;
   } queue_outcome_type;

   // directed row; reps repeats the request with value, value+1, ...
   typedef struct packed {
      req_kind_type           kind;
      logic [DATA_W-1:0]      value;
      logic [4:0]             reps;
      logic                   typed;      // outcome below is used, not the shadow queue
      queue_outcome_type      outcome;
   } directed_row_type;

   localparam int NUM_ROWS = 23;
   localparam directed_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      // empty queue
      '{REQ_DEQUEUE, 32'h0000_0000, 5'd1,  1'b1, '{STS_EMPTY, 32'h0, 1'b0, 5'd0}},
      '{REQ_SEARCH,  32'h0000_0000, 5'd1,  1'b1, '{STS_OK,    32'h0, 1'b0, 5'd0}},
      '{REQ_NOP,     32'hFFFF_FFFF, 5'd1,  1'b1, '{STS_OK,    32'h0, 1'b0, 5'd0}},
      // extremes of the value field
      '{REQ_ENQUEUE, 32'h8000_0000, 5'd1,  1'b1, '{STS_OK,    32'h0, 1'b0, 5'd0}},
      '{REQ_ENQUEUE, 32'h7FFF_FFFF, 5'd1,  1'b1, '{STS_OK,    32'h0, 1'b0, 5'd0}},
      '{REQ_SEARCH,  32'h8000_0000, 5'd1,  1'b1, '{STS_OK,    32'h0, 1'b1, 5'd1}},
      '{REQ_SEARCH,  32'h7FFF_FFFF, 5'd1,  1'b1, '{STS_OK,    32'h0, 1'b1, 5'd2}},
      '{REQ_SEARCH,  32'h0000_0000, 5'd1,  1'b1, '{STS_OK,    32'h0, 1'b0, 5'd0}},
      // near miss: one bit off the head value
      '{REQ_SEARCH,  32'h8000_0001, 5'd1,  1'b1, '{STS_OK,    32'h0, 1'b0, 5'd0}},
      '{REQ_DEQUEUE, 32'h0000_0000, 5'd1,  1'b1, '{STS_OK,    32'h8000_0000, 1'b0, 5'd0}},
      // fill to the brim, wrapping the tail
      '{REQ_ENQUEUE, 32'hFFFF_FFF0, 5'd15, 1'b1, '{STS_OK,    32'h0, 1'b0, 5'd0}},
      '{REQ_ENQUEUE, 32'h1234_5678, 5'd1,  1'b1, '{STS_FULL,  32'h0, 1'b0, 5'd0}},
      '{REQ_SEARCH,  32'hFFFF_FFFE, 5'd1,  1'b1, '{STS_OK,    32'h0, 1'b1, 5'd16}},
      '{REQ_SEARCH,  32'h1234_5678, 5'd1,  1'b1, '{STS_OK,    32'h0, 1'b0, 5'd0}},
      '{REQ_NOP,     32'h0000_0000, 5'd1,  1'b1, '{STS_OK,    32'h0, 1'b0, 5'd0}},
      // drain completely, head wraps too
      '{REQ_DEQUEUE, 32'h0000_0000, 5'd16, 1'b0, '{STS_OK,    32'h0, 1'b0, 5'd0}},
      '{REQ_DEQUEUE, 32'hFFFF_FFFF, 5'd1,  1'b1, '{STS_EMPTY, 32'h0, 1'b0, 5'd0}},
      // duplicates: search reports the oldest match
      '{REQ_ENQUEUE, 32'h0000_0005, 5'd1,  1'b1, '{STS_OK,    32'h0, 1'b0, 5'd0}},
      '{REQ_ENQUEUE, 32'h0000_0009, 5'd1,  1'b1, '{STS_OK,    32'h0, 1'b0, 5'd0}},
      '{REQ_ENQUEUE, 32'h0000_0005, 5'd1,  1'b1, '{STS_OK,    32'h0, 1'b0, 5'd0}},
      '{REQ_SEARCH,  32'h0000_0005, 5'd1,  1'b1, '{STS_OK,    32'h0, 1'b1, 5'd1}},
      '{REQ_DEQUEUE, 32'h0000_0000, 5'd1,  1'b1, '{STS_OK,    32'h5, 1'b0, 5'd0}},
      '{REQ_SEARCH,  32'h0000_0005, 5'd1,  1'b0, '{STS_OK,    32'h0, 1'b0, 5'd0}}
   };

   // DUT side
   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   req_kind_type              req_type = REQ_NOP;
   logic signed [DATA_W-1:0]  req_value = '0;
   logic                      rsp_valid;
   logic [1:0]                rsp_status;
   logic signed [DATA_W-1:0]  rsp_data_out;
   logic                      rsp_found;
   logic [POS_W-1:0]          rsp_position;

   // travel with each request so the monitor sees them at the accepting edge
   logic                      row_typed = 1'b0;
   queue_outcome_type         row_outcome = '0;

   // shadow queue: head/tail ring plus occupancy
   logic [DATA_W-1:0]         shadow_cells [QUEUE_DEPTH];
   int unsigned               shadow_head = 0;
   int unsigned               shadow_tail = 0;
   int unsigned               shadow_count = 0;

   queue_outcome_type         pending_results [$];
   int unsigned               mismatch_count = 0;

   // driver side only; recent enqueue values feed search hits
   logic [DATA_W-1:0]         recent_values [$];
   bit                        idling_on = 1'b1;

   searchable_fifo_queue u_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_type     (req_type),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_status   (rsp_status),
      .rsp_data_out (rsp_data_out),
      .rsp_found    (rsp_found),
      .rsp_position (rsp_position)
   );

   always begin
      #CLOCK_HIGH_NS clock = 1'b1;
      #CLOCK_LOW_NS  clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Prediction: apply one request to the shadow queue, return its result.
   // Searches only walk occupied slots, so never-written slots are never read.
   // ---------------------------------------------------------------------------
   function automatic queue_outcome_type predict_outcome(req_kind_type kind,
                                                         logic [DATA_W-1:0] value);
      queue_outcome_type o;
      int unsigned       slot;
      o = '{status: STS_OK, data: '0, found: 1'b0, position: '0};
      case (kind)
         REQ_ENQUEUE: begin
            if (shadow_count >= QUEUE_DEPTH) begin
               o.status = STS_FULL;          // dropped, nothing moves
            end else begin
               shadow_cells[shadow_tail] = value;
               shadow_tail  = (shadow_tail + 1) % QUEUE_DEPTH;
               shadow_count = shadow_count + 1;
            end
         end
         REQ_DEQUEUE: begin
            if (shadow_count == 0) begin
               o.status = STS_EMPTY;
            end else begin
               o.data       = shadow_cells[shadow_head];
               shadow_head  = (shadow_head + 1) % QUEUE_DEPTH;
               shadow_count = shadow_count - 1;
            end
         end
         REQ_SEARCH: begin
            slot = shadow_head;
            // full 32-bit compare, first (oldest) match wins
            for (int k = 0; k < shadow_count && !o.found; k++) begin
               if (shadow_cells[slot] == value) begin
                  o.found    = 1'b1;
                  o.position = POS_W'(k + 1);  // low bits only on wide depths
               end
               slot = (slot + 1) % QUEUE_DEPTH;
            end
         end
         default: ;                          // no-op: nothing moves, all zero
      endcase
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                  logic [DATA_W-1:0] want);
      if (mismatch_count < PRINT_LIMIT)
         $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
      mismatch_count++;
   endtask

   // ---------------------------------------------------------------------------
   // Monitor. Results are checked before the transfer at the same edge is
   // predicted, so a result can never be matched against its own request.
   // All sampling happens at the rising edge, before any NBA update lands.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : result_monitor
      queue_outcome_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result strobe with no transfer pending",
                            rsp_data_out, '0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", DATA_W'(rsp_status), DATA_W'(want.status));
            if (rsp_data_out !== want.data)
               report_mismatch("data_out", rsp_data_out, want.data);
            if (rsp_found !== want.found)
               report_mismatch("found", DATA_W'(rsp_found), DATA_W'(want.found));
            if (rsp_position !== want.position)
               report_mismatch("position", DATA_W'(rsp_position), DATA_W'(want.position));
         end
      end
      if (!reset && start && !busy) begin
         // shadow state always advances; typed rows override the prediction
         want = predict_outcome(req_type, req_value);
         if (row_typed)
            want = row_outcome;
         pending_results.push_back(want);
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------

   // mostly back to back, some short gaps, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(99);
      if (!idling_on || roll < 55) return 0;
      if (roll < 85) return $urandom_range(3, 1);
      if (roll < 97) return $urandom_range(10, 4);
      return $urandom_range(40, 20);
   endfunction

   // small pool gives duplicates, extremes hit sign and carry edges
   function automatic logic [DATA_W-1:0] pick_value();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 30) return DATA_W'($urandom_range(7));
      if (roll < 40) begin
         case ($urandom_range(4))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0001;
            default: return 32'h0000_0000;
         endcase
      end
      return $urandom;
   endfunction

   // mostly values that are likely held, some one-bit near misses
   function automatic logic [DATA_W-1:0] pick_search_value();
      int unsigned roll;
      logic [DATA_W-1:0] held;
      roll = $urandom_range(99);
      if (recent_values.size() == 0 || roll >= 65)
         return pick_value();
      held = recent_values[$urandom_range(recent_values.size() - 1)];
      if (roll < 55)
         return held;
      return held ^ (32'h1 << $urandom_range(DATA_W - 1));
   endfunction

   // One transfer: present it, hold start until accepted, then maybe idle.
   // start stays high across back-to-back transfers, never dropped and raised
   // in one time step.
   task automatic issue_request(req_kind_type kind, logic [DATA_W-1:0] value,
                                logic typed, queue_outcome_type outcome);
      int unsigned gap;
      req_type    <= kind;
      req_value   <= value;
      row_typed   <= typed;
      row_outcome <= outcome;
      start       <= 1'b1;
      do @(posedge clock); while (busy);
      if (kind == REQ_ENQUEUE) begin
         recent_values.push_back(value);
         if (recent_values.size() > RECENT_DEPTH)
            void'(recent_values.pop_front());
      end
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // sender holds off until every pending result is back
   task automatic wait_for_drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin : stimulus
      int unsigned    sent;
      int unsigned    segment_left;
      int unsigned    mode;
      int unsigned    roll;
      req_kind_type   kind;
      logic [DATA_W-1:0] value;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (DIRECTED_ROWS[r]) begin
         for (int i = 0; i < DIRECTED_ROWS[r].reps; i++)
            issue_request(DIRECTED_ROWS[r].kind, DIRECTED_ROWS[r].value + DATA_W'(i),
                          DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].outcome);
      end
      wait_for_drain();

      // random phases: fill-biased, drain-biased and balanced, so the queue
      // keeps hitting both full and empty; some phases run with no idling
      sent         = 0;
      segment_left = 0;
      mode         = 0;
      while (sent < RANDOM_ITEMS) begin
         if (segment_left == 0) begin
            segment_left = $urandom_range(60, 20);
            mode         = $urandom_range(2);
            idling_on    = ($urandom_range(3) != 0);
         end
         segment_left--;

         roll = $urandom_range(99);
         case (mode)
            0:       kind = (roll < 55) ? REQ_ENQUEUE : (roll < 70) ? REQ_DEQUEUE :
                            (roll < 97) ? REQ_SEARCH  : REQ_NOP;
            1:       kind = (roll < 15) ? REQ_ENQUEUE : (roll < 70) ? REQ_DEQUEUE :
                            (roll < 97) ? REQ_SEARCH  : REQ_NOP;
            default: kind = (roll < 35) ? REQ_ENQUEUE : (roll < 65) ? REQ_DEQUEUE :
                            (roll < 97) ? REQ_SEARCH  : REQ_NOP;
         endcase

         case (kind)
            REQ_ENQUEUE: value = pick_value();
            REQ_SEARCH:  value = pick_search_value();
            default:     value = $urandom;    // ignored by the block
         endcase

         issue_request(kind, value, 1'b0, '0);
         if (kind != REQ_NOP) begin
            sent++;
            if (sent % DRAIN_EVERY == 0)
               wait_for_drain();
         end
      end

      // wrap up: everything back, then a few quiet cycles for stray strobes
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch("results never returned", DATA_W'(pending_results.size()), '0);

      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // hang guard, sized far above the slowest legal run
   initial begin : watchdog
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", CYCLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

endmodule

>>> searchable_fifo_queue.f
rtl/core/sfq_pkg.sv
rtl/core/sfq_cell.sv
rtl/core/sfq_first_hit.sv
rtl/core/searchable_fifo_queue.sv
bench/searchable_fifo_queue_test.sv
